// ===== src/acpc_pkg.sv =====
package acpc_pkg;

  localparam int NumLanes = 4;
  localparam int BlockW   = 128;
  localparam int CountW   = 5;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int NumRounds = 10;
  localparam int RoundW   = 4;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIvHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIvLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMode    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYX,
    ST_RUN,
    ST_OUT1,
    ST_PADRUN,
    ST_OUT2
  } state_t;

  typedef struct packed {
    logic load;
    logic inverse;
    logic final_rnd;
    logic [RoundW-1:0] rnd;
  } lane_ctl_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] inv_sub_byte(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (Sbox[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] blk_byte(input logic [BlockW-1:0] b, input int i);
    return b[BlockW-1-8*i -: 8];
  endfunction

endpackage

// ===== src/acpc_if.sv =====
interface acpc_in_if;
  import acpc_pkg::*;
  logic valid;
  logic ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [CountW-1:0] byte_count;
  logic last;
  modport source (output valid, data_high, data_low, byte_count, last, input ready);
  modport sink (input valid, data_high, data_low, byte_count, last, output ready);
endinterface

interface acpc_out_if;
  import acpc_pkg::*;
  logic valid;
  logic ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [CountW-1:0] valid_bytes;
  logic pad_error;
  logic run_last;
  logic message_end;
  modport source (output valid, result_high, result_low, valid_bytes, pad_error, run_last,
                  message_end, input ready);
  modport sink (input valid, result_high, result_low, valid_bytes, pad_error, run_last,
                message_end, output ready);
endinterface

// ===== src/aes128_cbc_pkcs7_cipher_unit.sv =====
// channel | dir | payload
// in_     | in  | data_high, data_low, byte_count, last
// out_    | out | result_high, result_low, valid_bytes, pad_error, run_last, message_end
// cfg_    | in  | wr_en, index (3b), data (64b)
// each block steps through load, round-0 key add, ten rounds on four column lanes and
// the output register; a full last encrypt block adds a second pass for the padding
// block, and a short decrypt block skips the rounds and returns a pad error.
// the key schedule holds off requests after reset or a key write until all round keys are stored.
// a stalled out_ holds the block; the next request waits until the result is taken.
// reset is synchronous, rst_n low.
module aes128_cbc_pkcs7_cipher_unit
  import acpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  acpc_in_if.sink             in_ch,
  acpc_out_if.source          out_ch,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  logic [BlockW-1:0] key_r, iv_r, chain_r, chain_nxt;
  logic mode_r, start_r, start_nxt;
  state_t state_r, state_nxt;
  logic [RoundW-1:0] rnd_r, rnd_nxt, rd_rnd;
  logic last_r, last_nxt, extra_r, extra_nxt, dec_r, dec_nxt;
  logic [BlockW-1:0] cip_r, cip_nxt, load_blk, state_blk, shifted, rkey, fin_blk;
  logic [BlockW-1:0] res_r, res_nxt;
  logic [CountW-1:0] vb_r, vb_nxt;
  logic err_r, err_nxt, rl_r, rl_nxt, me_r, me_nxt;
  logic key_busy, key_start;
  lane_ctl_t ctl;
  logic [31:0] lane_col [NumLanes];
  logic [31:0] lane_nxt [NumLanes];

  assign key_start = cfg_wr_en && (cfg_index == RegKeyHigh || cfg_index == RegKeyLow);

  acpc_keyexp u_keyexp (
    .clk, .rst_n, .start(key_start),
    .key(cfg_index == RegKeyHigh ? {cfg_data, key_r[63:0]} : {key_r[127:64], cfg_data}),
    .rd_rnd, .rd_key(rkey), .busy(key_busy)
  );

  // merged state from the four lanes and its row shift, inverse when decrypting
  always_comb begin
    for (int c = 0; c < NumLanes; c++) begin
      state_blk[BlockW-1-32*c -: 32] = lane_col[c];
      fin_blk[BlockW-1-32*c -: 32] = lane_nxt[c];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[BlockW-1-8*(4*c+r) -: 8] = dec_r ? blk_byte(state_blk, 4*((c+4-r)%4)+r)
                                                 : blk_byte(state_blk, 4*((c+r)%4)+r);
      end
    end
  end

  genvar g;
  for (g = 0; g < NumLanes; g++) begin : g_lane
    acpc_lane u_lane (
      .clk, .ctl,
      .load_col(load_blk[BlockW-1-32*g -: 32]),
      .shifted_col(shifted[BlockW-1-32*g -: 32]),
      .rkey_col(rkey[BlockW-1-32*g -: 32]),
      .col_nxt(lane_nxt[g]),
      .col_r(lane_col[g])
    );
  end

  logic [CountW-1:0] cnt;
  logic [BlockW-1:0] padded, chain_use, plain;
  logic [7:0] pb;
  logic pad_bad;

  always_comb begin
    cnt = (in_ch.byte_count > CountW'(16)) ? CountW'(16) : in_ch.byte_count;
    padded = {in_ch.data_high, in_ch.data_low};
    if (in_ch.last && cnt < CountW'(16)) begin
      for (int i = 0; i < 16; i++) begin
        if (CountW'(i) >= cnt) padded[BlockW-1-8*i -: 8] = 8'(CountW'(16) - cnt);
      end
    end
  end

  // plaintext after decrypt and padding check, taken from the final round output
  always_comb begin
    plain = fin_blk ^ chain_r;
    pb = plain[7:0];
    pad_bad = (pb == 8'd0) || (pb > 8'd16);
    for (int i = 0; i < 16; i++) begin
      if (8'(i) < pb && plain[8*i +: 8] != pb) pad_bad = 1'b1;
    end
  end

  assign chain_use = chain_r;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    last_nxt = last_r;
    extra_nxt = extra_r;
    dec_nxt = dec_r;
    cip_nxt = cip_r;
    chain_nxt = chain_r;
    start_nxt = start_r;
    res_nxt = res_r;
    vb_nxt = vb_r;
    err_nxt = err_r;
    rl_nxt = rl_r;
    me_nxt = me_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && !key_busy) begin
          last_nxt = in_ch.last;
          dec_nxt = mode_r;
          cip_nxt = {in_ch.data_high, in_ch.data_low};
          if (start_r) chain_nxt = iv_r;
          start_nxt = in_ch.last;
          extra_nxt = !mode_r && in_ch.last && cnt == CountW'(16);
          if (mode_r && cnt < CountW'(16)) begin
            res_nxt = '0;
            vb_nxt = '0;
            err_nxt = 1'b1;
            rl_nxt = 1'b1;
            me_nxt = in_ch.last;
            state_nxt = ST_OUT2;
          end else begin
            rnd_nxt = '0;
            state_nxt = ST_KEYX;
          end
        end
      end
      ST_KEYX: begin
        rnd_nxt = rnd_r + 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN, ST_PADRUN: begin
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RoundW'(NumRounds)) begin
          rnd_nxt = '0;
          if (dec_r) begin
            res_nxt = plain;
            chain_nxt = cip_r;
            vb_nxt = CountW'(16);
            err_nxt = 1'b0;
            if (last_r) begin
              err_nxt = pad_bad;
              vb_nxt = pad_bad ? CountW'(0) : CountW'(16) - CountW'(pb);
            end
          end else begin
            res_nxt = fin_blk;
            chain_nxt = fin_blk;
            vb_nxt = CountW'(16);
            err_nxt = 1'b0;
          end
          rl_nxt = !(extra_r && state_r == ST_RUN);
          me_nxt = last_r && rl_nxt;
          state_nxt = (state_r == ST_RUN && extra_r) ? ST_OUT1 : ST_OUT2;
        end
      end
      ST_OUT1: begin
        if (out_ch.ready) begin
          rnd_nxt = '0;
          state_nxt = ST_PADRUN;
        end
      end
      ST_OUT2: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // load data: first pass takes the request, padding pass the chain
  always_comb begin
    if (state_r == ST_OUT1) begin
      load_blk = chain_r ^ {16{8'h10}};
    end else if (mode_r) begin
      load_blk = {in_ch.data_high, in_ch.data_low};
    end else begin
      load_blk = padded ^ (start_r ? iv_r : chain_use);
    end
  end

  always_comb begin
    ctl.load = (state_r == ST_IDLE) || (state_r == ST_OUT1);
    ctl.inverse = dec_r;
    ctl.rnd = rnd_r;
    ctl.final_rnd = (rnd_r == RoundW'(NumRounds));
    // prefetch one key ahead; round 0 key applied in the cycle after load
    rd_rnd = dec_nxt ? RoundW'(NumRounds) - rnd_nxt : rnd_nxt;
  end

  always_ff @(posedge clk) begin
    cip_r <= cip_nxt;
    res_r <= res_nxt;
    vb_r <= vb_nxt;
    err_r <= err_nxt;
    rl_r <= rl_nxt;
    me_r <= me_nxt;
    last_r <= last_nxt;
    extra_r <= extra_nxt;
    chain_r <= chain_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r <= '0;
      dec_r <= 1'b0;
      mode_r <= 1'b0;
      start_r <= 1'b1;
      key_r <= '0;
      iv_r <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r <= rnd_nxt;
      dec_r <= dec_nxt;
      start_r <= start_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          RegKeyHigh: key_r[127:64] <= cfg_data;
          RegKeyLow:  key_r[63:0] <= cfg_data;
          RegIvHigh:  iv_r[127:64] <= cfg_data;
          RegIvLow:   iv_r[63:0] <= cfg_data;
          RegMode:    mode_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE) && !key_busy;
  assign out_ch.valid = (state_r == ST_OUT1) || (state_r == ST_OUT2);
  assign out_ch.result_high = res_r[127:64];
  assign out_ch.result_low = res_r[63:0];
  assign out_ch.valid_bytes = vb_r;
  assign out_ch.pad_error = err_r;
  assign out_ch.run_last = rl_r;
  assign out_ch.message_end = me_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("accept while result pending");
  a_me_rl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.message_end |-> out_ch.run_last) else $error("end without run last");
  a_out1: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT1 |-> !out_ch.run_last) else $error("first of two marked last");
endmodule

// ===== src/acpc_lane.sv =====
// one column of the aes state: four s-box bytes, mix column, round key
module acpc_lane
  import acpc_pkg::*;
(
  input  logic        clk,
  input  lane_ctl_t   ctl,
  input  logic [31:0] load_col,
  input  logic [31:0] shifted_col,
  input  logic [31:0] rkey_col,
  output logic [31:0] col_nxt,
  output logic [31:0] col_r
);
  logic [7:0] s [4];
  logic [7:0] a [4];
  logic [7:0] m [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      s[r] = ctl.inverse ? inv_sub_byte(shifted_col[31-8*r -: 8])
                         : Sbox[shifted_col[31-8*r -: 8]];
    end
    for (int r = 0; r < 4; r++) begin
      // inverse order: add key before inverse mix
      a[r] = ctl.inverse ? (s[r] ^ rkey_col[31-8*r -: 8]) : s[r];
    end
    for (int r = 0; r < 4; r++) begin
      if (!ctl.inverse) begin
        m[r] = xt(a[r]) ^ xt(a[(r+1)%4]) ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      end else begin
        m[r] = (xt(xt(xt(a[r]))) ^ xt(xt(a[r])) ^ xt(a[r]))
             ^ (xt(xt(xt(a[(r+1)%4]))) ^ xt(a[(r+1)%4]) ^ a[(r+1)%4])
             ^ (xt(xt(xt(a[(r+2)%4]))) ^ xt(xt(a[(r+2)%4])) ^ a[(r+2)%4])
             ^ (xt(xt(xt(a[(r+3)%4]))) ^ a[(r+3)%4]);
      end
    end
    if (ctl.load) begin
      col_nxt = load_col;
    end else if (ctl.rnd == '0) begin
      // round 0 is the key add alone
      col_nxt = col_r ^ rkey_col;
    end else if (ctl.final_rnd) begin
      col_nxt = {s[0], s[1], s[2], s[3]} ^ rkey_col;
    end else if (ctl.inverse) begin
      col_nxt = {m[0], m[1], m[2], m[3]};
    end else begin
      col_nxt = {m[0], m[1], m[2], m[3]} ^ rkey_col;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end
endmodule

// ===== src/acpc_keyexp.sv =====
// key schedule: one round key per cycle into a small memory
module acpc_keyexp
  import acpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [BlockW-1:0] key,
  input  logic [RoundW-1:0] rd_rnd,
  output logic [BlockW-1:0] rd_key,
  output logic              busy
);
  logic [BlockW-1:0] rk_mem [NumRounds+1];
  logic [BlockW-1:0] cur_r, cur_nxt;
  logic [RoundW-1:0] idx_r, idx_nxt;
  logic [7:0] rc_r, rc_nxt;
  logic busy_r, busy_nxt;
  logic [31:0] w0, w1, w2, w3, t;

  always_comb begin
    t  = {Sbox[cur_r[23:16]] ^ rc_r, Sbox[cur_r[15:8]], Sbox[cur_r[7:0]], Sbox[cur_r[31:24]]};
    w0 = cur_r[127:96] ^ t;
    w1 = cur_r[95:64] ^ w0;
    w2 = cur_r[63:32] ^ w1;
    w3 = cur_r[31:0] ^ w2;
    cur_nxt = cur_r;
    idx_nxt = idx_r;
    rc_nxt = rc_r;
    busy_nxt = busy_r;
    if (start) begin
      cur_nxt = key;
      idx_nxt = '0;
      rc_nxt = 8'h01;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cur_nxt = {w0, w1, w2, w3};
      rc_nxt = xt(rc_r);
      idx_nxt = idx_r + 1'b1;
      if (idx_r == RoundW'(NumRounds)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) rk_mem[idx_r] <= cur_r;
    rd_key <= rk_mem[rd_rnd];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cur_r <= '0;
      idx_r <= '0;
      rc_r <= 8'h01;
    end else begin
      busy_r <= busy_nxt;
      cur_r <= cur_nxt;
      idx_r <= idx_nxt;
      rc_r <= rc_nxt;
    end
  end

  assign busy = busy_r | start;
endmodule

// ===== dv/tb_checker.sv =====
`timescale 1ns / 100ps
module tb_checker
  import acpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  acpc_in_if                  in_ch,
  acpc_out_if                 out_ch,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending_results
);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  vbytes;
    logic        err;
    logic        run_last;
    logic        msg_end;
  } cipher_result_t;

  typedef logic [7:0] blk_t [16];

  cipher_result_t cipher_results_q[$];
  logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
  logic        dec_mode;
  logic [7:0]  chain [16];
  logic        msg_start;
  logic [7:0]  rkeys [176];
  logic [7:0]  inv_tbl [256];

  assign pending_results = cipher_results_q.size();

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  task automatic schedule_keys();
    logic [7:0] t [4];
    logic [7:0] s, rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rkeys[i] = key_hi[63-8*i -: 8];
      rkeys[8+i] = key_lo[63-8*i -: 8];
    end
    for (int w = 4; w < 44; w++) begin
      for (int k = 0; k < 4; k++) t[k] = rkeys[(w-1)*4+k];
      if (w % 4 == 0) begin
        s = t[0];
        t[0] = Sbox[t[1]] ^ rc;
        t[1] = Sbox[t[2]];
        t[2] = Sbox[t[3]];
        t[3] = Sbox[s];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      for (int k = 0; k < 4; k++) rkeys[w*4+k] = rkeys[(w-4)*4+k] ^ t[k];
    end
  endtask

  task automatic add_round(inout blk_t s, input int r);
    for (int i = 0; i < 16; i++) s[i] ^= rkeys[16*r+i];
  endtask

  task automatic shift_sub(inout blk_t s, input logic inv);
    blk_t o;
    int src;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        o[c*4+r] = inv ? inv_tbl[s[src*4+r]] : Sbox[s[src*4+r]];
      end
    s = o;
  endtask

  task automatic mix_cols(inout blk_t s, input logic inv);
    logic [7:0] m [4];
    logic [7:0] a [4];
    logic [7:0] v;
    if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = s[c*4+j];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int j = 0; j < 4; j++) v ^= gmul(a[j], m[(j + 4 - r) % 4]);
        s[c*4+r] = v;
      end
    end
  endtask

  task automatic encipher(inout blk_t s);
    add_round(s, 0);
    for (int r = 1; r < 10; r++) begin
      shift_sub(s, 1'b0);
      mix_cols(s, 1'b0);
      add_round(s, r);
    end
    shift_sub(s, 1'b0);
    add_round(s, 10);
  endtask

  task automatic decipher(inout blk_t s);
    add_round(s, 10);
    for (int r = 9; r > 0; r--) begin
      shift_sub(s, 1'b1);
      add_round(s, r);
      mix_cols(s, 1'b1);
    end
    shift_sub(s, 1'b1);
    add_round(s, 0);
  endtask

  function automatic cipher_result_t pack_result(input blk_t b, input int vb, input logic e);
    cipher_result_t r;
    for (int i = 0; i < 8; i++) begin
      r.hi[63-8*i -: 8] = b[i];
      r.lo[63-8*i -: 8] = b[8+i];
    end
    r.vbytes = 5'(vb);
    r.err = e;
    r.run_last = 1'b0;
    r.msg_end = 1'b0;
    return r;
  endfunction

  task automatic predict_block(input logic [63:0] dh, input logic [63:0] dl,
                               input logic [4:0] cnt_in, input logic lst);
    blk_t blk, cip, pb;
    cipher_result_t r0, r1;
    int cnt, p, vb;
    logic e, two;
    cnt = (cnt_in > 16) ? 16 : cnt_in;
    two = 1'b0;
    if (msg_start) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] = iv_hi[63-8*i -: 8];
        chain[8+i] = iv_lo[63-8*i -: 8];
      end
      msg_start = 1'b0;
    end
    for (int i = 0; i < 8; i++) begin
      blk[i] = dh[63-8*i -: 8];
      blk[8+i] = dl[63-8*i -: 8];
    end
    if (!dec_mode) begin
      if (lst && cnt < 16)
        for (int i = cnt; i < 16; i++) blk[i] = 8'(16 - cnt);
      for (int i = 0; i < 16; i++) blk[i] ^= chain[i];
      encipher(blk);
      r0 = pack_result(blk, 16, 1'b0);
      if (lst && cnt == 16) begin
        for (int i = 0; i < 16; i++) pb[i] = blk[i] ^ 8'h10;
        encipher(pb);
        r1 = pack_result(pb, 16, 1'b0);
        blk = pb;
        two = 1'b1;
      end
      chain = blk;
    end else if (cnt < 16) begin
      for (int i = 0; i < 16; i++) blk[i] = 8'h00;
      r0 = pack_result(blk, 0, 1'b1);
    end else begin
      cip = blk;
      decipher(blk);
      for (int i = 0; i < 16; i++) blk[i] ^= chain[i];
      chain = cip;
      vb = 16;
      e = 1'b0;
      if (lst) begin
        p = blk[15];
        if (p == 0 || p > 16) e = 1'b1;
        else for (int i = 0; i < p; i++) if (blk[15-i] != 8'(p)) e = 1'b1;
        vb = e ? 0 : 16 - p;
      end
      r0 = pack_result(blk, vb, e);
    end
    if (two) begin
      r1.run_last = 1'b1;
      r1.msg_end = lst;
      cipher_results_q.push_back(r0);
      cipher_results_q.push_back(r1);
    end else begin
      r0.run_last = 1'b1;
      r0.msg_end = lst;
      cipher_results_q.push_back(r0);
    end
    if (lst) msg_start = 1'b1;
  endtask

  cipher_result_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 256; i++) inv_tbl[Sbox[i]] = 8'(i);
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
      dec_mode = 1'b0;
      msg_start = 1'b1;
      for (int i = 0; i < 16; i++) chain[i] = 8'h00;
      schedule_keys();
      cipher_results_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          RegKeyHigh: begin key_hi = cfg_data; schedule_keys(); end
          RegKeyLow:  begin key_lo = cfg_data; schedule_keys(); end
          RegIvHigh:  iv_hi = cfg_data;
          RegIvLow:   iv_lo = cfg_data;
          RegMode:    dec_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        predict_block(in_ch.data_high, in_ch.data_low, in_ch.byte_count, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.result_high, out_ch.result_low, out_ch.valid_bytes,
                out_ch.pad_error, out_ch.run_last, out_ch.message_end};
        if (cipher_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = cipher_results_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h_%h vb %0d err %b rl %b me %b, got %h_%h vb %0d err %b rl %b me %b",
                       want.hi, want.lo, want.vbytes, want.err, want.run_last, want.msg_end,
                       got.hi, got.lo, got.vbytes, got.err, got.run_last, got.msg_end);
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import acpc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = RegKeyHigh;
  logic [CfgDataW-1:0] cfg_data = '0;
  int fail_count, pending_results;
  int send_idle_pct, recv_idle_pct;
  int idle_cycles;
  bit hold_off, done;

  acpc_in_if  in_ch();
  acpc_out_if out_ch();

  aes128_cbc_pkcs7_cipher_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tb_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (hold_off || !rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n || done)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("aes128_cbc_pkcs7_cipher_unit regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (30) @(posedge clk);
  endtask

  // leaves valid high after the accept; the next request takes it over or drops it, drain_wait drops it
  task automatic send_request(input logic [63:0] dh, input logic [63:0] dl,
                              input logic [4:0] cnt, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_high <= dh;
    in_ch.data_low <= dl;
    in_ch.byte_count <= cnt;
    in_ch.last <= lst;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // padded plaintext encrypted with the current key makes a valid decrypt message,
  // so random messages are mostly built from real ciphertexts produced by the dut
  logic [63:0] ct_hi [$];
  logic [63:0] ct_lo [$];
  always @(posedge clk)
    if (out_ch.valid && out_ch.ready && ct_hi.size() < 64) begin
      ct_hi.push_back(out_ch.result_high);
      ct_lo.push_back(out_ch.result_low);
    end

  task automatic random_message(input logic decrypting, inout int sent);
    int len;
    logic [4:0] cnt;
    len = $urandom_range(4, 1);
    for (int i = 0; i < len; i++) begin
      if (decrypting) begin
        cnt = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'd16;
        if (ct_hi.size() != 0 && $urandom_range(3) != 0)
          send_request(ct_hi.pop_front(), ct_lo.pop_front(), cnt, i == len - 1);
        else send_request(rand64(), rand64(), cnt, i == len - 1);
      end else begin
        cnt = (i == len - 1 || $urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'd16;
        send_request(rand64(), rand64(), cnt, i == len - 1);
      end
      sent++;
    end
  endtask

  task automatic run_phase(input int n, input logic decrypting);
    int sent;
    sent = 0;
    while (sent < n) begin
      random_message(decrypting, sent);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_high = '0;
    in_ch.data_low = '0;
    in_ch.byte_count = '0;
    in_ch.last = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (14) @(posedge clk);

    // directed: zero key, extremes of the fields, then all-ones key and iv in both modes
    send_request('0, '0, 5'd16, 1'b1);
    send_request('1, '1, 5'd0, 1'b1);
    send_request('1, '0, 5'd31, 1'b0);
    send_request('0, '1, 5'd3, 1'b0);
    send_request(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b1);
    send_request(rand64(), rand64(), 5'd1, 1'b1);
    drain_wait();
    write_reg(RegKeyHigh, '1);
    write_reg(RegKeyLow, '1);
    write_reg(RegIvHigh, '1);
    write_reg(RegIvLow, '1);
    send_request(rand64(), rand64(), 5'd16, 1'b0);
    send_request(rand64(), rand64(), 5'd8, 1'b1);
    drain_wait();
    write_reg(RegMode, 64'd1);
    send_request(rand64(), rand64(), 5'd16, 1'b0);
    send_request(rand64(), rand64(), 5'd5, 1'b0);
    send_request(rand64(), rand64(), 5'd20, 1'b1);
    send_request('0, '0, 5'd0, 1'b1);
    drain_wait();
    ct_hi.delete();
    ct_lo.delete();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 49 : 0;
      recv_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 29 : 0;
      write_reg(RegKeyHigh, rand64());
      write_reg(RegKeyLow, rand64());
      write_reg(RegIvHigh, rand64());
      write_reg(RegIvLow, rand64());
      write_reg(RegMode, 64'd0);
      ct_hi.delete();
      ct_lo.delete();
      if (ph == 4) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clk);
            hold_off <= 1'b0;
          end
          run_phase(62, 1'b0);
        join
      end else run_phase(62, 1'b0);
      drain_wait();
      // decrypt with the same key and iv so the captured ciphertexts meet the key that made them
      write_reg(RegMode, 64'd1);
      run_phase(62, 1'b1);
      drain_wait();
    end

    done = 1'b1;
    if (fail_count == 0) $display("aes128_cbc_pkcs7_cipher_unit regression: pass");
    else $display("aes128_cbc_pkcs7_cipher_unit regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/acpc_pkg.sv
src/acpc_if.sv
src/acpc_lane.sv
src/acpc_keyexp.sv
src/aes128_cbc_pkcs7_cipher_unit.sv
dv/tb_checker.sv
dv/tb_top.sv
